[rtl/fbpa_pkg.sv]
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

  // field widths
  localparam int IDX_W      = 10;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 11;
  localparam int BSIZE_W    = 16;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // pool limits
  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int ALIGN_BYTES    = 4;
  localparam int ALIGN_MASK     = ALIGN_BYTES - 1;
  localparam int AVAIL_CAP      = 2047;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_SIZE  = 2'd1,
    STAT_ALIGN = 2'd2,
    STAT_NOMEM = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_START = 2'd0,
    CFG_POOL_SIZE  = 2'd1,
    CFG_BLOCK_SIZE = 2'd2
  } cfg_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_INIT,
    S_HOLD
  } state_e;

  // one result item
  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   granted_index;
    logic [ADDR_W-1:0]  granted_address;
    logic [CNT_W-1:0]   free_blocks;
    logic [CNT_W-1:0]   pool_blocks;
  } res_t;

endpackage

[rtl/fbpa_if.sv]
// request and response channel interfaces of the fixed block pool allocator
interface fbpa_req_if import fbpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  logic [ADDR_W-1:0]   granted_address;
  logic [CNT_W-1:0]    free_blocks;
  logic [CNT_W-1:0]    pool_blocks;

  modport source (output valid, output status, output granted_index,
                  output granted_address, output free_blocks, output pool_blocks,
                  input ready);
  modport sink   (input valid, input status, input granted_index,
                  input granted_address, input free_blocks, input pool_blocks,
                  output ready);
endinterface

[rtl/fbpa_ram.sv]
// generic single write port ram with registered read
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fixed_block_pool_allocator_unit.sv]
// fixed block pool allocator: free list of block indexes kept in a link ram
// free, op code 3, a failed alloc and a rejected init answer through the output register alone;
//   a granted alloc goes through the link ram read, then head update and address add
// init walks the N linked blocks: the walk writes one link ram entry a cycle
// throughput: one free per cycle while the output is not stalled; no request is taken during a
//   granted alloc; a result waits in the output register while the next item is taken
// reset clears control state and the config registers; the link ram is not cleared
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fbpa_req_if.sink              req,
  fbpa_rsp_if.source            rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // widths that follow from the pool depth
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int PW = LW + BSIZE_W;
  localparam int NW = ((LW + BSIZE_W + 1) > ADDR_W + 2) ? (LW + BSIZE_W + 1) : (ADDR_W + 2);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    start_q;
  logic [ADDR_W-1:0]    psize_q;
  logic [BSIZE_W-1:0]   bsize_q;
  logic [LW-1:0]        head_q, head_d;
  logic [CW-1:0]        avail_q, avail_d;
  logic [LW-1:0]        whole_q, whole_d;
  logic [AW-1:0]        walk_q, walk_d;
  logic [NW-1:0]        nxt_q, nxt_d;
  logic [PW-1:0]        prod_q, prod_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_wdata, ram_rdata;

  logic                 accept, slot_free, new_res, out_load, last_blk;
  logic                 size_err, align_err, can_alloc, idx_ok;
  status_e              new_status;
  logic [IDX_W-1:0]     new_gidx;
  logic [ADDR_W-1:0]    new_gaddr;
  res_t                 new_val;

  // link memory
  fbpa_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // handshake and checks
  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid_q || rsp.ready;
  assign size_err  = (bsize_q == '0) ||
                     ({1'b0, psize_q} < {{(ADDR_W - BSIZE_W){1'b0}}, bsize_q, 1'b0});
  assign align_err = ((start_q & ADDR_W'(ALIGN_MASK)) != '0) ||
                     ((bsize_q & BSIZE_W'(ALIGN_MASK)) != '0) ||
                     ((psize_q & ADDR_W'(ALIGN_MASK)) != '0);
  assign can_alloc = (avail_q != '0) && (head_q < NULL_LINK);
  assign idx_ok    = {{(32 - IDX_W){1'b0}}, req.block_index} < 32'(MAX_BLOCKS);
  assign last_blk  = (nxt_q > NW'(psize_q)) || (walk_q == AW'(MAX_BLOCKS - 1));

  // next state, free list update and result
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    avail_d    = avail_q;
    whole_d    = whole_q;
    walk_d     = walk_q;
    nxt_d      = nxt_q;
    prod_d     = prod_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    new_res    = 1'b0;
    new_status = STAT_OK;
    new_gidx   = '0;
    new_gaddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(req.operation))
            OP_INIT: begin
              if (size_err) begin
                new_res    = 1'b1;
                new_status = STAT_SIZE;
              end else if (align_err) begin
                new_res    = 1'b1;
                new_status = STAT_ALIGN;
              end else begin
                walk_d  = '0;
                nxt_d   = NW'(bsize_q) << 1;
                state_d = S_INIT;
              end
            end
            OP_ALLOC: begin
              if (can_alloc) begin
                ram_re  = 1'b1;
                prod_d  = PW'(head_q) * PW'(bsize_q);
                state_d = S_ALLOC;
              end else begin
                new_res    = 1'b1;
                new_status = STAT_NOMEM;
              end
            end
            OP_FREE: begin
              new_res = 1'b1;
              if (idx_ok) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(req.block_index);
                ram_wdata = head_q;
                head_d    = LW'(req.block_index);
                if (avail_q < CW'(AVAIL_CAP)) begin
                  avail_d = avail_q + CW'(1);
                end
              end
            end
            default: begin
              new_res = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // pop: successor comes back from the link ram
        head_d    = ram_rdata;
        avail_d   = avail_q - CW'(1);
        new_res   = 1'b1;
        new_gidx  = IDX_W'(head_q);
        new_gaddr = start_q + ADDR_W'(prod_q);
        state_d   = S_IDLE;
      end
      S_INIT: begin
        // link block walk_q to its successor, or close the list
        ram_we    = 1'b1;
        ram_waddr = walk_q;
        ram_wdata = last_blk ? NULL_LINK : (LW'(walk_q) + LW'(1));
        if (last_blk) begin
          head_d  = '0;
          avail_d = CW'(walk_q) + CW'(1);
          whole_d = LW'(walk_q) + LW'(1);
          new_res = 1'b1;
          state_d = S_IDLE;
        end else begin
          walk_d = walk_q + AW'(1);
          nxt_d  = nxt_q + NW'(bsize_q);
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
    endcase

    new_val.status          = new_status;
    new_val.granted_index   = new_gidx;
    new_val.granted_address = new_gaddr;
    new_val.free_blocks     = CNT_W'(avail_d);
    new_val.pool_blocks     = CNT_W'(whole_d);

    // park the result while the output register is still taken
    if (new_res && !slot_free) begin
      res_d   = new_val;
      state_d = S_HOLD;
    end
  end

  // output register
  assign out_load = slot_free && (new_res || (state_q == S_HOLD));
  always_comb begin
    out_d       = new_res ? new_val : res_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_LINK;
      avail_q     <= '0;
      whole_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      avail_q     <= avail_d;
      whole_q     <= whole_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      psize_q <= '0;
      bsize_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_POOL_START: start_q <= cfg_wdata_i;
        CFG_POOL_SIZE:  psize_q <= cfg_wdata_i;
        CFG_BLOCK_SIZE: bsize_q <= cfg_wdata_i[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    nxt_q  <= nxt_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.status          = out_q.status;
  assign rsp.granted_index   = out_q.granted_index;
  assign rsp.granted_address = out_q.granted_address;
  assign rsp.free_blocks     = out_q.free_blocks;
  assign rsp.pool_blocks     = out_q.pool_blocks;

endmodule

[rtl/fbpa_checker.sv]
// port level checks of the fixed block pool allocator and their binding
module fbpa_checker import fbpa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [IDX_W-1:0]    rsp_granted_index_i,
  input logic [ADDR_W-1:0]   rsp_granted_address_i,
  input logic [CNT_W-1:0]    rsp_free_blocks_i,
  input logic [CNT_W-1:0]    rsp_pool_blocks_i
);

  logic [2:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = req_valid_i && req_ready_i;
  assign out_xfer = rsp_valid_i && rsp_ready_i;

  // items taken whose result transfer is still due
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_granted_index_i) && $stable(rsp_granted_address_i) &&
      $stable(rsp_free_blocks_i) && $stable(rsp_pool_blocks_i))
    else $error("stalled result changed");

  // at most one item in work and one result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= 3'd2)
    else $error("more than two items outstanding");

  // no result without an item behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_i |-> pend_q != 3'd0)
    else $error("result without a taken item");

  // no result shown after a reset cycle
  assert property (@(posedge clk_i) !rst_ni |=> !rsp_valid_i)
    else $error("result valid during reset");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req.valid),
  .req_ready_i           (req.ready),
  .rsp_valid_i           (rsp.valid),
  .rsp_ready_i           (rsp.ready),
  .rsp_status_i          (rsp.status),
  .rsp_granted_index_i   (rsp.granted_index),
  .rsp_granted_address_i (rsp.granted_address),
  .rsp_free_blocks_i     (rsp.free_blocks),
  .rsp_pool_blocks_i     (rsp.pool_blocks)
);

[tb/fbpa_grant_checker.sv]
// grant checker: tracks the allocator's free list and compares every response transfer
`timescale 1ns / 100ps

module fbpa_grant_checker import fbpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fbpa_req_if                   req_mon,
  fbpa_rsp_if                   rsp_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_BLOCKS_DEF);

  // shadow pool settings
  logic [ADDR_W-1:0]  pool_base;
  logic [ADDR_W-1:0]  pool_len;
  logic [BSIZE_W-1:0] blk_len;

  // shadow free list
  logic [CNT_W-1:0] link_mem [MAX_BLOCKS_DEF];
  logic [CNT_W-1:0] head_blk;
  logic [CNT_W-1:0] avail_blks;
  logic [CNT_W-1:0] total_blks;

  res_t pending_grants [$];

  // apply one request to the shadow list and return the response it should produce
  function automatic res_t predict_grant(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    res_t              r;
    logic [ADDR_W-1:0] n;
    r.status          = STAT_OK;
    r.granted_index   = '0;
    r.granted_address = '0;
    case (op)
      OP_INIT: begin
        if (blk_len == 0 || {1'b0, pool_len} < {16'b0, blk_len, 1'b0}) begin
          r.status = STAT_SIZE;
        end else if (pool_base % ALIGN_BYTES != 0 || blk_len % ALIGN_BYTES != 0 ||
                     pool_len % ALIGN_BYTES != 0) begin
          r.status = STAT_ALIGN;
        end else begin
          n = pool_len / {16'b0, blk_len};
          if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
          // chain blocks in order, block 0 first
          for (int i = 0; i < n; i++) begin
            link_mem[i] = (i + 1 < n) ? CNT_W'(i + 1) : NULL_LINK;
          end
          head_blk   = '0;
          avail_blks = n[CNT_W-1:0];
          total_blks = n[CNT_W-1:0];
        end
      end
      OP_ALLOC: begin
        if (avail_blks != 0 && head_blk < NULL_LINK) begin
          r.granted_index   = head_blk[IDX_W-1:0];
          r.granted_address = pool_base + ADDR_W'(head_blk) * ADDR_W'(blk_len);
          head_blk          = link_mem[head_blk[IDX_W-1:0]];
          avail_blks        = avail_blks - 1'b1;
        end else begin
          r.status = STAT_NOMEM;
        end
      end
      OP_FREE: begin
        // pushed as given, no ownership check
        link_mem[idx] = head_blk;
        head_blk      = CNT_W'(idx);
        if (avail_blks < AVAIL_CAP) avail_blks = avail_blks + 1'b1;
      end
      default: ;
    endcase
    r.free_blocks = avail_blks;
    r.pool_blocks = total_blks;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
    fail_count_o++;
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
  endtask

  // watch the channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pool_base    = '0;
      pool_len     = '0;
      blk_len      = '0;
      head_blk     = NULL_LINK;
      avail_blks   = '0;
      total_blks   = '0;
      pending_grants.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // response transfer first: its expectation is always older than a same-edge request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_grants.size() == 0) begin
          fail_count_o++;
          $display("%0t: response transfer with nothing expected, status %0d",
                   $time, rsp_mon.status);
        end else begin
          want = pending_grants.pop_front();
          if (rsp_mon.status !== want.status)
            report_field("status", want.status, rsp_mon.status);
          if (rsp_mon.granted_index !== want.granted_index)
            report_field("granted_index", want.granted_index, rsp_mon.granted_index);
          if (rsp_mon.granted_address !== want.granted_address)
            report_field("granted_address", want.granted_address, rsp_mon.granted_address);
          if (rsp_mon.free_blocks !== want.free_blocks)
            report_field("free_blocks", want.free_blocks, rsp_mon.free_blocks);
          if (rsp_mon.pool_blocks !== want.pool_blocks)
            report_field("pool_blocks", want.pool_blocks, rsp_mon.pool_blocks);
        end
      end
      if (req_mon.valid && req_mon.ready)
        pending_grants.push_back(predict_grant(req_mon.operation, req_mon.block_index));
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_START: pool_base = cfg_wdata_i;
          CFG_POOL_SIZE:  pool_len  = cfg_wdata_i;
          CFG_BLOCK_SIZE: blk_len   = cfg_wdata_i[BSIZE_W-1:0];
          default: ;
        endcase
      end
      pending_o = pending_grants.size();
    end
  end

endmodule

[tb/tb.sv]
// testbench top: clock, reset, pool setup and request traffic for the block pool allocator
`timescale 1ns / 100ps

module tb;
  import fbpa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int PHASES         = 13;
  localparam int FLOOD_PHASE    = 6;
  localparam int FLOOD_FREES    = 64;
  localparam int FLOOD_ALLOCS   = 60;
  localparam int ITEMS_PER_PASS = 46;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count;
  logic                  steady_flow;

  // ops in flight and blocks currently handed out, for well-formed frees
  logic [OP_W-1:0]  op_log [$];
  logic [IDX_W-1:0] held_blocks [$];

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fbpa_grant_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // response back-pressure
  always @(negedge clk_i) begin
    rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 11);
  end

  // follow granted blocks so frees mostly return what was handed out
  always @(posedge clk_i) begin
    logic [OP_W-1:0] op;
    if (rsp_ch.valid && rsp_ch.ready && op_log.size() != 0) begin
      op = op_log.pop_front();
      if (rsp_ch.status == STAT_OK) begin
        if (op == OP_ALLOC) held_blocks.push_back(rsp_ch.granted_index);
        else if (op == OP_INIT) held_blocks.delete();
      end
    end
    if (req_ch.valid && req_ch.ready) op_log.push_back(req_ch.operation);
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    while (!steady_flow && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.block_index <= idx;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop requesting and wait for every response
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // write all three pool registers, block idle
  task automatic setup_pool(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] size,
                            input logic [BSIZE_W-1:0] bsize);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_POOL_START;
    cfg_wdata_i <= start;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_POOL_SIZE;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_BLOCK_SIZE;
    cfg_wdata_i <= CFG_DATA_W'(bsize);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // return a held block, or allocate when none is held
  task automatic free_held();
    int               k;
    logic [IDX_W-1:0] idx;
    if (held_blocks.size() == 0) begin
      send_item(OP_ALLOC, '0);
    end else begin
      k   = $urandom_range(held_blocks.size() - 1);
      idx = held_blocks[k];
      held_blocks.delete(k);
      send_item(OP_FREE, idx);
    end
  endtask

  // random pool geometry, mostly valid and small
  task automatic pick_pool(output logic [ADDR_W-1:0] start, output logic [ADDR_W-1:0] size,
                           output logic [BSIZE_W-1:0] bsize);
    int                kind;
    int                count;
    logic [ADDR_W-1:0] bsz;
    kind  = $urandom_range(9);
    start = $urandom & ~ADDR_W'(ALIGN_MASK);
    case (kind)
      0: begin
        // raw values: mostly size or alignment errors
        start = $urandom;
        size  = $urandom_range(300);
        bsize = BSIZE_W'($urandom_range(200));
      end
      1: begin
        // as many blocks as the list holds, or more
        bsz   = ALIGN_BYTES * $urandom_range(1, 16);
        size  = bsz * $urandom_range(MAX_BLOCKS_DEF, 2000);
        bsize = bsz[BSIZE_W-1:0];
      end
      2: begin
        bsz   = ALIGN_BYTES * $urandom_range(16'h3000, 16'h3FFF);
        count = $urandom_range(2, 8);
        size  = bsz * count + ALIGN_BYTES * $urandom_range(0, bsz / ALIGN_BYTES - 1);
        bsize = bsz[BSIZE_W-1:0];
      end
      default: begin
        bsz   = ALIGN_BYTES * $urandom_range(1, 64);
        count = $urandom_range(2, 24);
        size  = bsz * count + ALIGN_BYTES * $urandom_range(0, bsz / ALIGN_BYTES - 1);
        bsize = bsz[BSIZE_W-1:0];
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  size;
    logic [BSIZE_W-1:0] bsize;
    int                 pick;
    rst_ni             = 1'b0;
    steady_flow        = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_POOL_START;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_INIT;
    req_ch.block_index = '0;
    rsp_ch.ready       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list, free before any init, unused op code
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 10'h3FF);
    send_item(OP_ALLOC, '0);
    send_item(OP_UNUSED, 10'h2AA);

    // zero block size, pool too small, each alignment error
    drain();
    setup_pool('0, '0, '0);
    send_item(OP_INIT, '0);
    drain();
    setup_pool('0, 32'd12, 16'd8);
    send_item(OP_INIT, '0);
    drain();
    setup_pool(32'hFFFF_FFFC, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_INIT, '0);
    drain();
    setup_pool(32'd2, 32'd64, 16'd8);
    send_item(OP_INIT, '0);
    drain();
    setup_pool('0, 32'd66, 16'd8);
    send_item(OP_INIT, '0);
    drain();
    setup_pool('0, 32'd64, 16'd6);
    send_item(OP_INIT, '0);

    // two-block pool: exhaust, double free, allocate from the broken list
    drain();
    setup_pool(32'd16, 32'd16, 16'd8);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 10'd1);
    send_item(OP_FREE, 10'd1);
    send_item(OP_ALLOC, '0);

    // saturated pools, address wrap past the top of memory
    drain();
    setup_pool(32'hFFFF_FFFC, 32'hFFFF_FFFC, 16'd4);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    drain();
    setup_pool('0, 32'hFFFF_FFFC, 16'hFFFC);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);

    // random passes, each with its own pool
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == FLOOD_PHASE) begin
        // full pool flooded with frees, then allocations, no idling
        steady_flow = 1'b1;
        setup_pool($urandom & ~ADDR_W'(ALIGN_MASK), ALIGN_BYTES * MAX_BLOCKS_DEF,
                   BSIZE_W'(ALIGN_BYTES));
        send_item(OP_INIT, '0);
        repeat (FLOOD_FREES) send_item(OP_FREE, IDX_W'($urandom_range(1023)));
        repeat (FLOOD_ALLOCS) send_item(OP_ALLOC, '0);
        drain();
        steady_flow = 1'b0;
      end else begin
        pick_pool(start, size, bsize);
        setup_pool(start, size, bsize);
        send_item(OP_INIT, '0);
        for (int n = 0; n < ITEMS_PER_PASS; n++) begin
          pick = $urandom_range(99);
          if (pick < 50) send_item(OP_ALLOC, IDX_W'($urandom_range(1023)));
          else if (pick < 85) free_held();
          else if (pick < 91) send_item(OP_FREE, IDX_W'($urandom_range(1023)));
          else if (pick < 95) send_item(OP_UNUSED, IDX_W'($urandom_range(1023)));
          else send_item(OP_INIT, IDX_W'($urandom_range(1023)));
        end
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
